// File: rtl/core/tcw_pkg.sv
// Shared types and constants of the text console character writer.
// No dependencies; imported by every module of the block.
package tcw_pkg;

  localparam int unsigned RowCellsDef    = 80;
  localparam int unsigned ScreenCellsDef = 2000;

  // Fixed widths of the payload fields
  localparam int unsigned CharW  = 8;
  localparam int unsigned AttrW  = 8;
  localparam int unsigned CellOW = 11;
  localparam int unsigned CfgW   = 8;
  localparam int unsigned ColorW = 4;

  localparam logic [CharW-1:0]  CH_BS    = 8'd8;
  localparam logic [CharW-1:0]  CH_LF    = 8'd10;
  localparam logic [CharW-1:0]  CH_CR    = 8'd13;
  localparam logic [CharW-1:0]  CH_SPACE = 8'd32;

  localparam logic [AttrW-1:0]  BLANK_ATTR  = 8'h07;
  localparam logic [AttrW-1:0]  TEXT_COLOR_RST = 8'h07;
  localparam logic [ColorW-1:0] CYCLE_LOW   = 4'h9;
  localparam logic [ColorW-1:0] CYCLE_HIGH  = 4'hF;

  typedef enum logic [0:0] {
    REG_TEXT_COLOR   = 1'b0,
    REG_RADIANT_MODE = 1'b1
  } tcw_reg_e;

  typedef struct packed {
    logic [AttrW-1:0] text_color;
    logic             radiant_mode;
  } tcw_cfg_t;

  typedef struct packed {
    logic              write_enable;
    logic [CellOW-1:0] cell_index;
    logic [CharW-1:0]  glyph;
    logic [AttrW-1:0]  attribute;
    logic [CellOW-1:0] cursor_after;
  } tcw_result_t;

endpackage

// File: rtl/core/tcw_if.sv
// Valid/ready channel interfaces: character input and cell-write result.
// Depends on nothing.
interface tcw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface tcw_cell_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [10:0] cell_index;
  logic [7:0]  glyph;
  logic [7:0]  attribute;
  logic [10:0] cursor_after;

  modport source (output valid, output write_enable, output cell_index, output glyph,
                  output attribute, output cursor_after, input ready);
  modport sink   (input valid, input write_enable, input cell_index, input glyph,
                  input attribute, input cursor_after, output ready);
endinterface

// File: rtl/core/tcw_in_reg.sv
// Input register stage: holds one accepted character until the processing
// stage takes it. Depends on tcw_pkg.
module tcw_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [tcw_pkg::CharW-1:0] in_char_i,
  input  logic                      take_i,
  output logic                      valid_o,
  output logic [tcw_pkg::CharW-1:0] char_o
);
  import tcw_pkg::*;

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q;
  logic             load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= in_char_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;

  a_take_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> valid_q) else $error("take without a held character");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q) else $error("accepted character not held");

  a_full_no_take_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !take_i) |-> !in_ready_o) else $error("overwrite of held character");

endmodule

// File: rtl/core/tcw_char_unit.sv
// Cursor state and per-character decode: works out the cell write and the
// new cursor in one pass. Depends on tcw_pkg.
module tcw_char_unit #(
  parameter int unsigned ROW_CELLS    = tcw_pkg::RowCellsDef,
  parameter int unsigned SCREEN_CELLS = tcw_pkg::ScreenCellsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [tcw_pkg::CharW-1:0] char_i,
  input  tcw_pkg::tcw_cfg_t         cfg_i,
  output tcw_pkg::tcw_result_t      result_o
);
  import tcw_pkg::*;

  localparam int unsigned CellW = $clog2(SCREEN_CELLS);
  localparam int unsigned ColW  = $clog2(ROW_CELLS);
  // cursor may pass the screen end by up to a row before wrapping
  localparam int unsigned SumW  = $clog2(SCREEN_CELLS + ROW_CELLS);
  localparam int unsigned ExtW  = (CellW > CellOW) ? CellW : CellOW;

  logic [CellW-1:0]  cell_q, cell_d;
  logic [ColW-1:0]   col_q, col_d, col_nx;
  logic [ColorW-1:0] cycle_q, cycle_d;

  logic             is_nl, is_bs, is_sp, radiant;
  logic [AttrW-1:0] attr;
  logic [SumW-1:0]  cell_ext, sum;
  logic             we;
  logic [CellW-1:0] wr_cell;
  logic [CharW-1:0] glyph;
  logic [AttrW-1:0] oattr;
  logic [ExtW-1:0]  wr_cell_x, cursor_x;

  always_comb begin
    is_nl   = (char_i == CH_LF) || (char_i == CH_CR);
    is_bs   = (char_i == CH_BS);
    is_sp   = (char_i == CH_SPACE);
    radiant = cfg_i.radiant_mode && !is_sp && !is_nl && !is_bs;

    attr    = cfg_i.text_color;
    cycle_d = cycle_q;
    if (radiant) begin
      attr = AttrW'(cycle_q);
      if (cycle_q >= CYCLE_HIGH || cycle_q < CYCLE_LOW) begin
        cycle_d = CYCLE_LOW;
      end else begin
        cycle_d = cycle_q + ColorW'(1);
      end
    end

    cell_ext = SumW'(cell_q);
    sum      = cell_ext;
    col_nx   = col_q;
    we       = 1'b0;
    wr_cell  = '0;
    glyph    = '0;
    oattr    = '0;

    if (is_nl) begin
      sum    = cell_ext + SumW'(ROW_CELLS) - SumW'(col_q);
      col_nx = '0;
    end else if (is_bs) begin
      if (cell_q != '0) begin
        sum = cell_ext - SumW'(1);
        if (col_q == '0) begin
          col_nx = ColW'(ROW_CELLS - 1);
        end else begin
          col_nx = col_q - ColW'(1);
        end
        we      = 1'b1;
        wr_cell = CellW'(sum);
        glyph   = CH_SPACE;
        oattr   = BLANK_ATTR;
      end
    end else begin
      we      = 1'b1;
      wr_cell = cell_q;
      glyph   = char_i;
      oattr   = attr;
      sum     = cell_ext + SumW'(1);
      if (col_q == ColW'(ROW_CELLS - 1)) begin
        col_nx = '0;
      end else begin
        col_nx = col_q + ColW'(1);
      end
    end

    // screen end: back to the top-left cell
    if (sum >= SumW'(SCREEN_CELLS)) begin
      cell_d = '0;
      col_d  = '0;
    end else begin
      cell_d = CellW'(sum);
      col_d  = col_nx;
    end

    wr_cell_x = ExtW'(wr_cell);
    cursor_x  = ExtW'(cell_d);

    result_o.write_enable = we;
    result_o.cell_index   = wr_cell_x[CellOW-1:0];
    result_o.glyph        = glyph;
    result_o.attribute    = oattr;
    result_o.cursor_after = cursor_x[CellOW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q  <= '0;
      col_q   <= '0;
      cycle_q <= CYCLE_LOW;
    end else if (step_i) begin
      cell_q  <= cell_d;
      col_q   <= col_d;
      cycle_q <= cycle_d;
    end
  end

  a_cycle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cycle_q >= CYCLE_LOW) && (cycle_q <= CYCLE_HIGH)) else $error("colour out of range");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < ROW_CELLS) else $error("column past row end");

  a_cell_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cell_q) < SCREEN_CELLS) else $error("cursor past screen end");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(cell_q) && $stable(col_q) && $stable(cycle_q))
    else $error("cursor moved without a character");

endmodule

// File: rtl/core/text_console_char_writer.sv
// Top level of the text console character writer: configuration registers,
// input stage, character unit and result register. Depends on tcw_pkg, tcw_if.
//
// Usage: characters arrive on char_i (valid/ready), one byte per transfer.
// Every accepted character gives exactly one result on cell_o: a cell write
// (write_enable, cell_index, glyph, attribute) and the cursor afterwards.
// CR/LF give write_enable 0 with zero write fields; so does backspace at cell 0.
// A taken character passes the input register, then the result register, to
// cell_o. Throughput is one character per cycle while cell_o is ready, set by
// the combinational cursor add, compare and wrap.
// Configuration (text_color index 0, radiant_mode index 1) is written with
// cfg_we_i; the user must write only while nothing is in flight (unchecked).
// Reset: cursor at cell 0, column 0, cycling colour 9, text_color 7,
// radiant_mode 0, both stages empty.
// When cell_o is stalled, the held result stays; the input register still
// takes one further character, after which char_i.ready drops.
module text_console_char_writer #(
  parameter int unsigned ROW_CELLS    = tcw_pkg::RowCellsDef,
  parameter int unsigned SCREEN_CELLS = tcw_pkg::ScreenCellsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_index_i,
  input  logic [tcw_pkg::CfgW-1:0] cfg_wdata_i,
  tcw_char_if.sink                 char_i,
  tcw_cell_if.source               cell_o
);
  import tcw_pkg::*;

  tcw_cfg_t    cfg_q;
  logic        held_valid, take;
  logic [CharW-1:0] held_char;
  tcw_result_t result, result_q;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_color   <= TEXT_COLOR_RST;
      cfg_q.radiant_mode <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (tcw_reg_e'(cfg_index_i))
        REG_TEXT_COLOR:   cfg_q.text_color   <= cfg_wdata_i;
        REG_RADIANT_MODE: cfg_q.radiant_mode <= cfg_wdata_i[0];
      endcase
    end
  end

  assign take = held_valid && (!out_valid_q || cell_o.ready);

  tcw_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .in_ready_o (char_i.ready),
    .in_char_i  (char_i.char_code),
    .take_i     (take),
    .valid_o    (held_valid),
    .char_o     (held_char)
  );

  tcw_char_unit #(
    .ROW_CELLS    (ROW_CELLS),
    .SCREEN_CELLS (SCREEN_CELLS)
  ) u_char_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (take),
    .char_i   (held_char),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (cell_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      result_q <= result;
    end
  end

  assign cell_o.valid        = out_valid_q;
  assign cell_o.write_enable = result_q.write_enable;
  assign cell_o.cell_index   = result_q.cell_index;
  assign cell_o.glyph        = result_q.glyph;
  assign cell_o.attribute    = result_q.attribute;
  assign cell_o.cursor_after = result_q.cursor_after;

  a_take_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_q) else $error("processed character lost");

  a_stall_blocks_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !cell_o.ready) |-> !take) else $error("result overwritten");

  a_no_write_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_q.write_enable) |->
      (result_q.cell_index == '0) && (result_q.glyph == '0) && (result_q.attribute == '0))
    else $error("fields set without a cell write");

endmodule

// File: tb/testbench.sv
// Self-checking bench for text_console_char_writer: a directed table, then random character
// streams under several colour settings, checked against a local cursor and colour model.
// Depends on tcw_pkg and the tcw_char_if / tcw_cell_if interfaces.
module testbench;
  import tcw_pkg::*;

  localparam int unsigned ROWS       = RowCellsDef;
  localparam int unsigned SCREEN     = ScreenCellsDef;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_LEN  = 200;

  typedef enum logic [1:0] {ROW_CHAR, ROW_CHECKED, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [7:0]  code;
    tcw_reg_e    reg_sel;
    logic [7:0]  wdata;
    tcw_result_t typed;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  tcw_reg_e cfg_index_i;
  logic [CfgW-1:0] cfg_wdata_i;

  tcw_char_if char_bus ();
  tcw_cell_if cell_bus ();

  text_console_char_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .char_i      (char_bus),
    .cell_o      (cell_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Model state
  logic [7:0]  text_colour = TEXT_COLOR_RST;
  logic        radiant     = 1'b0;
  logic [3:0]  cycle_colour = CYCLE_LOW;
  int unsigned cur_cell    = 0;
  int unsigned cur_col     = 0;

  tcw_result_t pending_cells[$];
  dir_row_t    dir_rows[$];
  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned n_chars     = 0;
  int unsigned n_writes    = 0;
  int unsigned n_wraps     = 0;
  int unsigned n_radiant   = 0;
  bit          quiet       = 1'b0;

  function automatic tcw_result_t next_cell_write(logic [7:0] c);
    tcw_result_t r;
    logic [7:0]  attr;
    r    = '0;
    attr = text_colour;
    if (radiant && c != CH_SPACE && c != CH_LF && c != CH_CR && c != CH_BS) begin
      attr = {4'h0, cycle_colour};
      n_radiant++;
      if (cycle_colour >= CYCLE_HIGH || cycle_colour < CYCLE_LOW) cycle_colour = CYCLE_LOW;
      else cycle_colour = cycle_colour + 4'd1;
    end
    if (c == CH_LF || c == CH_CR) begin
      cur_cell = cur_cell + ROWS - cur_col;
      cur_col  = 0;
    end else if (c == CH_BS) begin
      if (cur_cell > 0) begin
        cur_cell--;
        cur_col        = (cur_col == 0) ? ROWS - 1 : cur_col - 1;
        r.write_enable = 1'b1;
        r.cell_index   = 11'(cur_cell);
        r.glyph        = CH_SPACE;
        r.attribute    = BLANK_ATTR;
      end
    end else begin
      r.write_enable = 1'b1;
      r.cell_index   = 11'(cur_cell);
      r.glyph        = c;
      r.attribute    = attr;
      cur_cell++;
      cur_col++;
      if (cur_col >= ROWS) cur_col = 0;
    end
    if (cur_cell >= SCREEN) begin
      cur_cell = 0;
      cur_col  = 0;
      n_wraps++;
    end
    r.cursor_after = 11'(cur_cell);
    return r;
  endfunction

  function automatic dir_row_t char_row(logic [7:0] code);
    dir_row_t row;
    row      = '{kind: ROW_CHAR, code: code, reg_sel: REG_TEXT_COLOR, wdata: '0, typed: '0};
    return row;
  endfunction

  function automatic dir_row_t typed_row(logic [7:0] code, logic we, logic [10:0] cell_no,
                                         logic [7:0] glyph, logic [7:0] attr,
                                         logic [10:0] cursor);
    dir_row_t row;
    row       = char_row(code);
    row.kind  = ROW_CHECKED;
    row.typed = '{write_enable: we, cell_index: cell_no, glyph: glyph, attribute: attr,
                  cursor_after: cursor};
    return row;
  endfunction

  function automatic dir_row_t cfg_row(tcw_reg_e sel, logic [7:0] wdata);
    dir_row_t row;
    row         = char_row(8'h00);
    row.kind    = ROW_CFG;
    row.reg_sel = sel;
    row.wdata   = wdata;
    return row;
  endfunction

  // Registers only change with nothing in flight
  task automatic write_reg(tcw_reg_e sel, logic [7:0] wdata);
    char_bus.valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_wdata_i <= wdata;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (sel == REG_TEXT_COLOR) text_colour = wdata;
    else radiant = wdata[0];
  endtask

  task automatic send_char(logic [7:0] code, bit use_typed, tcw_result_t typed);
    int unsigned gap;
    tcw_result_t predicted;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= code;
    do @(posedge clk_i); while (!char_bus.ready);
    predicted = next_cell_write(code);
    pending_cells.push_back(use_typed ? typed : predicted);
    n_chars++;
    if (predicted.write_enable) n_writes++;
  endtask

  task automatic report(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Result side: check each transfer against the oldest expectation
  always @(posedge clk_i) begin
    tcw_result_t want;
    if (rst_ni && cell_bus.valid && cell_bus.ready) begin
      if (pending_cells.size() == 0) begin
        $display("%0t: unexpected result, cell %0d cursor %0d", $time,
                 cell_bus.cell_index, cell_bus.cursor_after);
        errors++;
      end else begin
        want = pending_cells.pop_front();
        report("write_enable", want.write_enable, cell_bus.write_enable);
        report("cell_index", want.cell_index, cell_bus.cell_index);
        report("glyph", want.glyph, cell_bus.glyph);
        report("attribute", want.attribute, cell_bus.attribute);
        report("cursor_after", want.cursor_after, cell_bus.cursor_after);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_cells.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver stalls
  initial begin
    int unsigned stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        cell_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      cell_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(cell_bus.valid && cell_bus.ready));
    end
  end

  initial begin
    int unsigned pick;
    int unsigned bs_left;
    logic [7:0]  code;
    logic [7:0]  colour;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= REG_TEXT_COLOR;
    cfg_wdata_i        <= '0;
    char_bus.valid     <= 1'b0;
    char_bus.char_code <= '0;
    bs_left            = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: reset state, control codes, byte extremes, colour cycling
    dir_rows.push_back(typed_row(CH_BS, 1'b0, 11'd0, 8'h00, 8'h00, 11'd0));
    dir_rows.push_back(typed_row(8'h41, 1'b1, 11'd0, 8'h41, 8'h07, 11'd1));
    dir_rows.push_back(typed_row(CH_LF, 1'b0, 11'd0, 8'h00, 8'h00, 11'd80));
    dir_rows.push_back(typed_row(CH_CR, 1'b0, 11'd0, 8'h00, 8'h00, 11'd160));
    dir_rows.push_back(typed_row(CH_BS, 1'b1, 11'd159, CH_SPACE, BLANK_ATTR, 11'd159));
    dir_rows.push_back(typed_row(8'h00, 1'b1, 11'd159, 8'h00, 8'h07, 11'd160));
    dir_rows.push_back(typed_row(8'hFF, 1'b1, 11'd160, 8'hFF, 8'h07, 11'd161));
    dir_rows.push_back(cfg_row(REG_TEXT_COLOR, 8'hFF));
    dir_rows.push_back(typed_row(CH_SPACE, 1'b1, 11'd161, CH_SPACE, 8'hFF, 11'd162));
    dir_rows.push_back(cfg_row(REG_TEXT_COLOR, 8'h00));
    dir_rows.push_back(char_row(8'h7F));
    dir_rows.push_back(cfg_row(REG_RADIANT_MODE, 8'h01));
    dir_rows.push_back(typed_row(8'h78, 1'b1, 11'd163, 8'h78, 8'h09, 11'd164));
    repeat (7) dir_rows.push_back(char_row(8'h78));  // runs 10..15 and back to 9
    dir_rows.push_back(char_row(CH_SPACE));
    dir_rows.push_back(char_row(CH_BS));
    dir_rows.push_back(char_row(CH_LF));
    dir_rows.push_back(char_row(8'h55));
    dir_rows.push_back(char_row(8'hAA));
    dir_rows.push_back(cfg_row(REG_RADIANT_MODE, 8'hFE));
    dir_rows.push_back(cfg_row(REG_TEXT_COLOR, TEXT_COLOR_RST));

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          write_reg(dir_rows[i].reg_sel, dir_rows[i].wdata);
        end
        ROW_CHECKED: begin
          send_char(dir_rows[i].code, 1'b1, dir_rows[i].typed);
        end
        default: begin
          send_char(dir_rows[i].code, 1'b0, '0);
        end
      endcase
    end

    // Random streams; each phase change drains the block before reprogramming
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: colour = 8'h00;
        1: colour = 8'hFF;
        default: colour = 8'($urandom_range(0, 255));
      endcase
      write_reg(REG_TEXT_COLOR, colour);
      write_reg(REG_RADIANT_MODE, {7'($urandom_range(0, 127)), 1'(p % 2 == 0)});
      quiet = (p % 3 == 1);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (bs_left > 0) begin
          code = CH_BS;
          bs_left--;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 3) begin
            bs_left = $urandom_range(1, 90);  // long backspace runs cross rows
            code    = CH_BS;
          end else if (pick < 50) code = 8'($urandom_range(0, 255));
          else if (pick < 58) code = CH_LF;
          else if (pick < 64) code = CH_CR;
          else if (pick < 72) code = CH_BS;
          else if (pick < 80) code = CH_SPACE;
          else code = 8'($urandom_range(33, 126));
        end
        send_char(code, 1'b0, '0);
      end
    end
    char_bus.valid <= 1'b0;
    quiet = 1'b0;

    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("Run covered %0d characters: %0d cell writes, %0d screen wraps,", n_chars,
             n_writes, n_wraps);
    $display("%0d radiant colour characters over %0d colour settings.", n_radiant, PHASES + 1);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: text_console_char_writer.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_if.sv
rtl/core/tcw_in_reg.sv
rtl/core/tcw_char_unit.sv
rtl/core/text_console_char_writer.sv
tb/testbench.sv
